@@ design/cycling_power_crank_reporter_core_macros.svh @@
// ----------------------------------------------------------------------------
// cycling power crank reporter - assertion macros
// shared property forms for the core's checks
// ----------------------------------------------------------------------------
`ifndef CYCLING_POWER_CRANK_REPORTER_CORE_MACROS_SVH
`define CYCLING_POWER_CRANK_REPORTER_CORE_MACROS_SVH

// expression must never hold outside reset
`define CPCR_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CPCR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/cpcr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpcr_pkg
// types and constants shared by the crank reporter front, queue and back
// ----------------------------------------------------------------------------
`default_nettype none

package cpcr_pkg;

  localparam int TICKS_PER_SECOND = 1024;

  localparam logic [9:0]  POWER_LIMIT = 10'd1000;
  localparam logic [15:0] CRANK_FLAGS = 16'h0020;

  // floor(2^20 / 15), used for the 2*cadence/15 step of the increment
  localparam logic [16:0] RECIP_15 = 17'd69905;

  // numerator of the event time advance per whole revolution
  localparam longint TIME_NUM = 64'd60 * TICKS_PER_SECOND * 64'd256;
  localparam int     DIVD_W   = $clog2(3 * TIME_NUM + 1);
  localparam int     DCNT_W   = $clog2(DIVD_W + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int INC_W = 18;

  typedef struct packed {
    logic [9:0]       power;
    logic [15:0]      cadence;
    logic [INC_W-1:0] inc;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ design/cpcr_front.sv @@
// ----------------------------------------------------------------------------
// cpcr_front
// accepts samples, drops zero cadence, forms power and revolution increment
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [15:0]          pendulum_angle,
  input  wire logic [15:0]          cadence,
  input  wire logic [9:0]           extra_power,
  input  wire cpcr_pkg::fifo_stat_t fifo_stat,
  output logic                      push,
  output cpcr_pkg::item_t           push_item
);
  import cpcr_pkg::*;

  logic        s1_valid;
  logic [32:0] prod;
  logic [16:0] dbl;
  logic [13:0] q_est;
  logic [15:0] craw;

  logic [33:0] recip_prod;
  logic        neg;
  logic [32:0] neg_prod;
  logic [31:0] mag;
  logic [32:0] mag_rnd;
  logic [18:0] rnd;
  logic [18:0] ext;
  logic [18:0] psum;
  logic [9:0]  power;
  logic [17:0] rem;
  logic [13:0] q_fix;

  assign recip_prod = 34'({cadence, 1'b0}) * 34'(RECIP_15);

  assign in_stall = s1_valid && fifo_stat.full;
  assign push     = s1_valid && !fifo_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid && (cadence != 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      prod  <= $signed(pendulum_angle) * $signed({1'b0, cadence});
      dbl   <= {cadence, 1'b0};
      q_est <= recip_prod[33:20];
      craw  <= cadence;
    end
  end

  // round halves away from zero, add extra power, clamp
  always_comb begin
    neg      = prod[32];
    neg_prod = -prod;
    mag      = neg ? neg_prod[31:0] : prod[31:0];
    mag_rnd  = {1'b0, mag} + 33'd32768;
    rnd      = {2'b00, mag_rnd[32:16]};
    ext      = {9'd0, extra_power};
    psum     = neg ? (ext - rnd) : (ext + rnd);
    if (psum[18]) begin
      power = 10'd0;
    end else if (psum > {9'd0, POWER_LIMIT}) begin
      power = POWER_LIMIT;
    end else begin
      power = psum[9:0];
    end
  end

  // floor(cadence*256/120) = 2*cadence + floor(2*cadence/15)
  always_comb begin
    rem   = {1'b0, dbl} - ({q_est, 4'd0} - {4'd0, q_est});
    q_fix = (rem >= 18'd15) ? (q_est + 14'd1) : q_est;
  end

  always_comb begin
    push_item.power   = power;
    push_item.cadence = craw;
    push_item.inc     = {1'b0, dbl} + {4'd0, q_fix};
  end

endmodule

`default_nettype wire

@@ design/cpcr_fifo.sv @@
// ----------------------------------------------------------------------------
// cpcr_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire cpcr_pkg::item_t      push_item,
  input  wire logic                 pop,
  output cpcr_pkg::item_t           pop_item,
  output cpcr_pkg::fifo_stat_t      fifo_stat
);
  import cpcr_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign fifo_stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign fifo_stat.empty = (count == '0);
  assign pop_item        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/cpcr_back.sv @@
// ----------------------------------------------------------------------------
// cpcr_back
// revolution bookkeeping, serial event time divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cpcr_pkg::item_t      pop_item,
  input  wire cpcr_pkg::fifo_stat_t fifo_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [9:0]                power_watts,
  output logic [15:0]               crank_revolutions,
  output logic [15:0]               crank_event_time
);
  import cpcr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state;
  logic [15:0]       residue;
  logic [15:0]       rev_count;
  logic [15:0]       event_time;
  logic [DIVD_W-1:0] divd;
  logic [15:0]       rem;
  logic [15:0]       quo;
  logic [DCNT_W-1:0] cnt;
  logic [15:0]       craw;
  logic [9:0]        power_r;
  logic [15:0]       rev_r;

  logic [INC_W-1:0]  sum;
  logic [1:0]        whole;
  logic [16:0]       trial;
  logic              fits;
  logic              out_free;

  assign pop      = (state == ST_IDLE) && !fifo_stat.empty;
  assign sum      = {2'b00, residue} + pop_item.inc;
  assign whole    = sum[INC_W-1:16];
  assign trial    = {rem, divd[DIVD_W-1]};
  assign fits     = trial >= {1'b0, craw};
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      residue    <= '0;
      rev_count  <= '0;
      event_time <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            residue   <= sum[15:0];
            rev_count <= rev_count + {14'd0, whole};
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == DCNT_W'(DIVD_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            event_time <= event_time + quo;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          divd    <= DIVD_W'(whole) * DIVD_W'(TIME_NUM);
          rem     <= '0;
          quo     <= '0;
          cnt     <= '0;
          craw    <= pop_item.cadence;
          power_r <= pop_item.power;
          rev_r   <= rev_count + {14'd0, whole};
        end
      end
      ST_DIV: begin
        rem  <= fits ? (trial[15:0] - craw) : trial[15:0];
        quo  <= {quo[14:0], fits};
        divd <= {divd[DIVD_W-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          power_watts       <= power_r;
          crank_revolutions <= rev_r;
          crank_event_time  <= event_time + quo;
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/cycling_power_crank_reporter_core.sv @@
// ----------------------------------------------------------------------------
// cycling power crank reporter core
// per-sample power, cumulative crank revolutions and crank event time
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid/in_stall with pendulum_angle (signed q8.8) and
//   cadence (unsigned q8.8). a request with zero cadence is taken and dropped.
//   output channel: out_valid/out_stall with power_watts, crank_revolutions,
//   crank_event_time and measurement_flags; one result per nonzero cadence.
//   cfg_wr_en/cfg_wr_data write extra_power; write only while idle.
//   path: front register, queue, then the back's divide and finish states.
//   the serial event time divider in the back part takes a new request only
//   when idle (one quotient bit per cycle, DIVD_W bits).
//   the front and a two-entry queue keep taking requests while the back works.
//   reset (rst, synchronous) clears extra_power, counters, residue, event time
//   and all valid state.
//   when the receiver stalls the result holds; the back finishes its divide
//   and waits, then the queue fills and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cycling_power_crank_reporter_core_macros.svh"

module cycling_power_crank_reporter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [9:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] pendulum_angle,
  input  wire logic [15:0] cadence,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       power_watts,
  output logic [15:0]      crank_revolutions,
  output logic [15:0]      crank_event_time,
  output logic [15:0]      measurement_flags
);
  import cpcr_pkg::*;

  logic       [9:0] extra_power;
  logic             push;
  logic             pop;
  item_t            push_item;
  item_t            pop_item;
  fifo_stat_t       fifo_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_power <= '0;
    end else if (cfg_wr_en) begin
      extra_power <= cfg_wr_data;
    end
  end

  assign measurement_flags = CRANK_FLAGS;

  cpcr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pendulum_angle (pendulum_angle),
    .cadence        (cadence),
    .extra_power    (extra_power),
    .fifo_stat      (fifo_stat),
    .push           (push),
    .push_item      (push_item)
  );

  cpcr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .fifo_stat (fifo_stat)
  );

  cpcr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .pop_item          (pop_item),
    .fifo_stat         (fifo_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .power_watts       (power_watts),
    .crank_revolutions (crank_revolutions),
    .crank_event_time  (crank_event_time)
  );

  `CPCR_ASSERT_NEVER(a_no_push_full, clk, rst, push && fifo_stat.full, "push into full queue")
  `CPCR_ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && fifo_stat.empty, "pop from empty queue")
  `CPCR_ASSERT_IMPLIES(a_power_limit, clk, rst, out_valid, power_watts <= POWER_LIMIT, "power over limit")

endmodule

`default_nettype wire
